// ----- hw/rtl/first_fit_block_allocator_unit_assert.svh -----
// assertion macros for the allocator rtl
// used by files that include it; expects clk and rst in scope
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_UNIT_ASSERT_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_UNIT_ASSERT_SVH

// same-cycle implication
`define FFA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FFA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/ffa_pkg.sv -----
// shared constants and types of the first-fit block allocator
// no dependencies
package ffa_pkg;

  localparam int NUM_BLOCKS_DEF = 32;
  localparam int SIZE_BITS_DEF  = 16;

  localparam int STATUS_W = 2;
  localparam int INDEX_W  = 5;
  localparam int VALUE_W  = 16;
  localparam int REQNUM_W = 10;

  typedef enum logic [STATUS_W-1:0] {
    ST_LOADED  = 2'd0,
    ST_FULL    = 2'd1,
    ST_GRANTED = 2'd2,
    ST_MISS    = 2'd3
  } status_t;

  typedef enum logic {
    REQ_LOAD  = 1'b0,
    REQ_ALLOC = 1'b1
  } req_kind_t;

endpackage

// ----- hw/rtl/ffa_mem.sv -----
// block table memory: one write port, one read port, registered read data
// depends on nothing
module ffa_mem #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 32,
  parameter int AW    = 5
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hw/rtl/ffa_ctrl.sv -----
// sequencer: load append, first-fit scan over the block table, result register
// depends on ffa_pkg and first_fit_block_allocator_unit_assert.svh
`include "first_fit_block_allocator_unit_assert.svh"

module ffa_ctrl #(
  parameter int NUM_BLOCKS = ffa_pkg::NUM_BLOCKS_DEF,
  parameter int SIZE_BITS  = ffa_pkg::SIZE_BITS_DEF,
  parameter int IDX_W      = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          req_type,
  input  logic [ffa_pkg::VALUE_W-1:0]   size_value,
  output logic                          done,
  output logic [ffa_pkg::STATUS_W-1:0]  status,
  output logic [ffa_pkg::INDEX_W-1:0]   block_index,
  output logic [ffa_pkg::VALUE_W-1:0]   block_size,
  output logic [ffa_pkg::VALUE_W-1:0]   free_left,
  output logic [ffa_pkg::REQNUM_W-1:0]  request_number,
  output logic                          mem_we,
  output logic [IDX_W-1:0]              mem_waddr,
  output logic [2*SIZE_BITS-1:0]        mem_wdata,
  output logic                          mem_re,
  output logic [IDX_W-1:0]              mem_raddr,
  input  logic [2*SIZE_BITS-1:0]        mem_rdata
);

  import ffa_pkg::*;

  localparam int CNT_W = $clog2(NUM_BLOCKS + 1);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } state_t;

  state_t               state;
  logic [CNT_W-1:0]     loaded;
  logic [REQNUM_W-1:0]  req_cnt;
  logic [REQNUM_W-1:0]  req_cnt_next;
  logic [SIZE_BITS-1:0] req_size;
  logic [IDX_W-1:0]     chk;

  logic                     accept;
  logic                     is_load;
  logic                     full;
  logic [SIZE_BITS+15:0]    in_wide;
  logic [SIZE_BITS-1:0]     in_size;
  logic [SIZE_BITS-1:0]     rd_free;
  logic [SIZE_BITS-1:0]     rd_orig;
  logic [SIZE_BITS-1:0]     free_after;
  logic                     fit;
  logic [CNT_W-1:0]         chk_succ;
  logic                     last;

  function automatic logic [VALUE_W-1:0] to_out(input logic [SIZE_BITS-1:0] v);
    logic [SIZE_BITS+VALUE_W-1:0] w;
    w = (SIZE_BITS + VALUE_W)'(v);
    return w[VALUE_W-1:0];
  endfunction

  function automatic logic [INDEX_W-1:0] to_idx(input logic [IDX_W-1:0] v);
    logic [IDX_W+INDEX_W-1:0] w;
    w = (IDX_W + INDEX_W)'(v);
    return w[INDEX_W-1:0];
  endfunction

  assign busy         = (state != S_IDLE);
  assign accept       = start && (state == S_IDLE);
  assign is_load      = (req_type == REQ_LOAD);
  assign full         = (loaded >= CNT_W'(NUM_BLOCKS));
  assign in_wide      = (SIZE_BITS + 16)'(size_value);
  assign in_size      = in_wide[SIZE_BITS-1:0];
  assign rd_free      = mem_rdata[SIZE_BITS-1:0];
  assign rd_orig      = mem_rdata[2*SIZE_BITS-1:SIZE_BITS];
  assign free_after   = rd_free - req_size;
  assign fit          = (rd_free >= req_size);
  assign chk_succ     = CNT_W'(chk) + CNT_W'(1);
  assign last         = (chk_succ == loaded);
  assign req_cnt_next = req_cnt + REQNUM_W'(1);

  // memory port use
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = '0;
    if (accept && is_load && !full) begin
      mem_we    = 1'b1;
      mem_waddr = loaded[IDX_W-1:0];
      mem_wdata = {in_size, in_size};
    end
    if (accept && !is_load && (loaded != '0)) begin
      mem_re    = 1'b1;
      mem_raddr = '0;
    end
    if (state == S_SCAN) begin
      if (fit) begin
        mem_we    = 1'b1;
        mem_waddr = chk;
        mem_wdata = {rd_orig, free_after};
      end else if (!last) begin
        mem_re    = 1'b1;
        mem_raddr = chk_succ[IDX_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      loaded  <= '0;
      req_cnt <= '0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (is_load) begin
              done <= 1'b1;
              if (!full) begin
                loaded         <= loaded + CNT_W'(1);
                status         <= ST_LOADED;
                block_index    <= to_idx(loaded[IDX_W-1:0]);
                block_size     <= to_out(in_size);
                free_left      <= to_out(in_size);
                request_number <= '0;
              end else begin
                status         <= ST_FULL;
                block_index    <= '0;
                block_size     <= '0;
                free_left      <= '0;
                request_number <= '0;
              end
            end else begin
              req_cnt  <= req_cnt_next;
              req_size <= in_size;
              chk      <= '0;
              if (loaded == '0) begin
                done           <= 1'b1;
                status         <= ST_MISS;
                block_index    <= '0;
                block_size     <= '0;
                free_left      <= '0;
                request_number <= req_cnt_next;
              end else begin
                state <= S_SCAN;
              end
            end
          end
        end
        S_SCAN: begin
          if (fit) begin
            done           <= 1'b1;
            status         <= ST_GRANTED;
            block_index    <= to_idx(chk);
            block_size     <= to_out(rd_orig);
            free_left      <= to_out(free_after);
            request_number <= req_cnt;
            state          <= S_IDLE;
          end else if (last) begin
            done           <= 1'b1;
            status         <= ST_MISS;
            block_index    <= '0;
            block_size     <= '0;
            free_left      <= '0;
            request_number <= req_cnt;
            state          <= S_IDLE;
          end else begin
            chk <= chk_succ[IDX_W-1:0];
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `FFA_ASSERT_NOW(a_no_rw_same_cycle, mem_we, !mem_re, "table read and write in one cycle")
  `FFA_ASSERT_NOW(a_count_bound, 1'b1, loaded <= CNT_W'(NUM_BLOCKS), "block count overflow")
  `FFA_ASSERT_NOW(a_done_when_idle, done, !busy, "result while scan still running")
  `FFA_ASSERT_NEXT(a_scan_reads, accept && !is_load && (loaded != '0), busy, "scan did not start")

endmodule

// ----- hw/rtl/first_fit_block_allocator_unit.sv -----
// top level of the first-fit block allocator
// depends on ffa_pkg, ffa_ctrl and ffa_mem
//
//  channel   | handshake              | payload
//  ----------+------------------------+---------------------------------------------
//  request   | start, busy            | req_type, size_value
//  result    | done (one-cycle pulse) | status, block_index, block_size, free_left,
//            |                        | request_number
//
// a load leaves busy low, and done pulses in the cycle after start is taken
// an allocate scans the table from entry 0 up to the first fit or the end of
// the loaded blocks (1 to NUM_BLOCKS entries read), one read per cycle from the
// table's single read port, with busy high during the scan; an empty table misses with no scan
// reset clears the state, done, the block count and request counter; the table itself is not cleared
// the receiver cannot stall: each result stays on the ports from its done pulse until the next result
module first_fit_block_allocator_unit #(
  parameter int NUM_BLOCKS = ffa_pkg::NUM_BLOCKS_DEF,
  parameter int SIZE_BITS  = ffa_pkg::SIZE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          req_type,
  input  logic [ffa_pkg::VALUE_W-1:0]   size_value,
  output logic                          done,
  output logic [ffa_pkg::STATUS_W-1:0]  status,
  output logic [ffa_pkg::INDEX_W-1:0]   block_index,
  output logic [ffa_pkg::VALUE_W-1:0]   block_size,
  output logic [ffa_pkg::VALUE_W-1:0]   free_left,
  output logic [ffa_pkg::REQNUM_W-1:0]  request_number
);

  import ffa_pkg::*;

  localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;

  logic                   mem_we;
  logic [IDX_W-1:0]       mem_waddr;
  logic [2*SIZE_BITS-1:0] mem_wdata;
  logic                   mem_re;
  logic [IDX_W-1:0]       mem_raddr;
  logic [2*SIZE_BITS-1:0] mem_rdata;

  ffa_ctrl #(
    .NUM_BLOCKS (NUM_BLOCKS),
    .SIZE_BITS  (SIZE_BITS),
    .IDX_W      (IDX_W)
  ) u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .req_type       (req_type),
    .size_value     (size_value),
    .done           (done),
    .status         (status),
    .block_index    (block_index),
    .block_size     (block_size),
    .free_left      (free_left),
    .request_number (request_number),
    .mem_we         (mem_we),
    .mem_waddr      (mem_waddr),
    .mem_wdata      (mem_wdata),
    .mem_re         (mem_re),
    .mem_raddr      (mem_raddr),
    .mem_rdata      (mem_rdata)
  );

  ffa_mem #(
    .DEPTH (NUM_BLOCKS),
    .WIDTH (2 * SIZE_BITS),
    .AW    (IDX_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule
